>>> hdl/alfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alfd_pkg
// Shared widths, command codes, register indexes and reset values of the
// addressable LED frame driver.
// ----------------------------------------------------------------------------
package alfd_pkg;

  localparam int LED_COUNT_DEF = 8;

  localparam int CHAN_W       = 8;
  localparam int PIXEL_W      = 3 * CHAN_W;
  localparam int BITS_PER_LED = PIXEL_W;
  localparam int BIT_PTR_W    = 5;
  localparam int PHASE_W      = 4;
  localparam int OP_W         = 2;
  localparam int INDEX_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL = 2'd2;
  localparam logic [OP_W-1:0] OP_SHOW = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 2'd2;

  // Configuration reset values
  localparam logic [CHAN_W-1:0]  MAX_BRIGHT_RST = 8'd64;
  localparam logic [PHASE_W-1:0] SHORT_RST      = 4'd3;
  localparam logic [PHASE_W-1:0] LONG_RST       = 4'd9;

  localparam int CHAN_FULL = 255;

endpackage

`default_nettype wire

>>> hdl/addressable_led_frame_driver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_frame_driver_core
// Frame store and single-wire serialiser for a chain of addressable LEDs.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------------
//  in      | in_op in_index in_red in_green in_blue | in_valid / in_ready
//  out     | out_data_line out_busy_res out_rejected| out_valid / out_ready
//  cfg     | cfg_index cfg_data                     | cfg_we, no wait
//
//  A word is handled in an accept step (frame store read of the LED being sent,
//  channel products registered) and an execute step (slot update or store write).
//  The registered read of the frame store is why a word needs both steps.
//  Fill then writes every LED of the store after its result is issued.
//  After reset a clearing pass writes every LED of the store with in_ready low.
//  A waiting result holds the next word in execute until out_ready.
// ----------------------------------------------------------------------------
module addressable_led_frame_driver_core #(
  parameter int LED_COUNT = alfd_pkg::LED_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [alfd_pkg::OP_W-1:0]      in_op,
  input  logic [alfd_pkg::INDEX_W-1:0]   in_index,
  input  logic [alfd_pkg::CHAN_W-1:0]    in_red,
  input  logic [alfd_pkg::CHAN_W-1:0]    in_green,
  input  logic [alfd_pkg::CHAN_W-1:0]    in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_data_line,
  output logic                           out_busy_res,
  output logic                           out_rejected,
  input  logic                           cfg_we,
  input  logic [alfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [alfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alfd_pkg::*;

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IW-1:0]        LED_LAST = IW'(LED_COUNT - 1);
  localparam logic [BIT_PTR_W-1:0] BIT_LAST = BIT_PTR_W'(BITS_PER_LED - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_FILL  = 4'b1000
  } state_t;

  state_t state_r;

  // configuration
  logic [CHAN_W-1:0]  max_bright_r;
  logic [PHASE_W-1:0] short_r;
  logic [PHASE_W-1:0] long_r;

  // latched command
  logic [OP_W-1:0]    op_r;
  logic [INDEX_W-1:0] idx_r;

  // serialiser state
  logic [IW-1:0]        led_r,    led_nxt;
  logic [BIT_PTR_W-1:0] bit_r,    bit_nxt;
  logic [PHASE_W-1:0]   phase_r,  phase_nxt;
  logic                 high_r,   high_nxt;
  logic                 sending_r, sending_nxt;
  logic                 line_r,   line_nxt;
  logic                 rej_nxt;

  logic [IW-1:0]        sweep_r;
  logic [PIXEL_W-1:0]   fill_word_r;

  logic                 out_valid_r;
  logic                 out_line_r;
  logic                 out_busy_r;
  logic                 out_rej_r;

  logic                 accept;
  logic                 exec_go;
  logic                 idx_ok;
  logic [CHAN_W-1:0]    red_s, green_s, blue_s;
  logic [PIXEL_W-1:0]   packed_word;
  logic [PIXEL_W-1:0]   cur_word;
  logic                 cur_bit;
  logic [PHASE_W-1:0]   dur;
  logic [PHASE_W-1:0]   pc_inc;
  logic                 phase_end;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [PIXEL_W-1:0]   mem_wdata;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign idx_ok   = ({{(32-INDEX_W){1'b0}}, idx_r} < 32'(LED_COUNT));

  alfd_scale u_scale_r (
    .clk(clk), .load(accept), .chan(in_red), .max_bright(max_bright_r), .scaled(red_s)
  );
  alfd_scale u_scale_g (
    .clk(clk), .load(accept), .chan(in_green), .max_bright(max_bright_r),
    .scaled(green_s)
  );
  alfd_scale u_scale_b (
    .clk(clk), .load(accept), .chan(in_blue), .max_bright(max_bright_r), .scaled(blue_s)
  );

  assign packed_word = {green_s, red_s, blue_s};

  // Read address follows the LED being sent; stores only change in execute or
  // sweep, both finished before the next accept, so the read is never stale.
  alfd_pixmem #(
    .DEPTH(LED_COUNT),
    .AW   (IW)
  ) u_pixmem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(led_r),
    .rd_data(cur_word)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_word_r;
      end
      ST_EXEC: begin
        if (exec_go && op_r == OP_SET && !sending_r && idx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(idx_r);
          mem_wdata = packed_word;
        end
      end
      default: begin
      end
    endcase
  end

  // bit timing of the current slot
  always_comb begin
    cur_bit   = cur_word[BIT_LAST - bit_r];
    if (high_r) begin
      dur = cur_bit ? long_r : short_r;
    end else begin
      dur = cur_bit ? short_r : long_r;
    end
    pc_inc    = phase_r + PHASE_W'(1);
    phase_end = (pc_inc >= dur) || (pc_inc == '0);
  end

  always_comb begin
    led_nxt     = led_r;
    bit_nxt     = bit_r;
    phase_nxt   = phase_r;
    high_nxt    = high_r;
    sending_nxt = sending_r;
    line_nxt    = line_r;
    rej_nxt     = 1'b0;
    if (op_r == OP_TICK) begin
      if (sending_r) begin
        line_nxt  = high_r;
        phase_nxt = pc_inc;
        if (phase_end) begin
          phase_nxt = '0;
          if (high_r) begin
            high_nxt = 1'b0;
          end else begin
            high_nxt = 1'b1;
            if (bit_r == BIT_LAST) begin
              bit_nxt = '0;
              if (led_r == LED_LAST) begin
                led_nxt     = '0;
                sending_nxt = 1'b0;
                high_nxt    = 1'b0;
              end else begin
                led_nxt = led_r + IW'(1);
              end
            end else begin
              bit_nxt = bit_r + BIT_PTR_W'(1);
            end
          end
        end
      end else begin
        line_nxt = 1'b0;
      end
    end else if (sending_r) begin
      rej_nxt = 1'b1;
    end else if (op_r == OP_SET) begin
      rej_nxt = !idx_ok;
    end else if (op_r == OP_SHOW) begin
      sending_nxt = 1'b1;
      led_nxt     = '0;
      bit_nxt     = '0;
      phase_nxt   = '0;
      high_nxt    = 1'b1;
      line_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r <= MAX_BRIGHT_RST;
      short_r      <= SHORT_RST;
      long_r       <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BRIGHT: max_bright_r <= cfg_data;
        CFG_SHORT:      short_r      <= cfg_data[PHASE_W-1:0];
        CFG_LONG:       long_r       <= cfg_data[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      led_r       <= '0;
      bit_r       <= '0;
      phase_r     <= '0;
      high_r      <= 1'b0;
      sending_r   <= 1'b0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR, ST_FILL: begin
          if (sweep_r == LED_LAST) begin
            sweep_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            sweep_r <= sweep_r + IW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            led_r       <= led_nxt;
            bit_r       <= bit_nxt;
            phase_r     <= phase_nxt;
            high_r      <= high_nxt;
            sending_r   <= sending_nxt;
            line_r      <= line_nxt;
            sweep_r     <= '0;
            state_r     <= (op_r == OP_FILL && !sending_r) ? ST_FILL : ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload: hold the command and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      idx_r <= in_index;
    end
    if (exec_go) begin
      fill_word_r <= packed_word;
      out_line_r  <= line_nxt;
      out_busy_r  <= sending_nxt;
      out_rej_r   <= rej_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_line = out_line_r;
  assign out_busy_res  = out_busy_r;
  assign out_rejected  = out_rej_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tick_never_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && op_r == OP_TICK) |=> !out_rejected)
    else $error("tick produced a rejected result");

  a_line_low_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> !line_r)
    else $error("data line high with no frame in progress");

  a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("frame store written while idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_waddr <= LED_LAST))
    else $error("frame store write beyond last LED");

endmodule

`default_nettype wire

>>> hdl/alfd_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alfd_scale
// Brightness scaler for one colour channel: registers chan * max_bright, then
// divides the product by 255 through a reciprocal estimate and one correction.
// ----------------------------------------------------------------------------
module alfd_scale (
  input  logic                        clk,
  input  logic                        load,
  input  logic [alfd_pkg::CHAN_W-1:0] chan,
  input  logic [alfd_pkg::CHAN_W-1:0] max_bright,
  output logic [alfd_pkg::CHAN_W-1:0] scaled
);
  import alfd_pkg::*;

  localparam logic [2*CHAN_W:0] FULL = (2*CHAN_W+1)'(CHAN_FULL);

  logic [2*CHAN_W-1:0] prod_r;
  logic [2*CHAN_W:0]   sum;
  logic [CHAN_W-1:0]   q_est;
  logic [2*CHAN_W:0]   q_times;
  logic [2*CHAN_W:0]   rem;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= (2*CHAN_W)'(chan) * (2*CHAN_W)'(max_bright);
    end
  end

  // x/255 ~ (x + x/256)/256: low by at most one, so one subtract-compare fixes it
  always_comb begin
    sum     = {1'b0, prod_r} + (2*CHAN_W+1)'(prod_r >> CHAN_W);
    q_est   = sum[2*CHAN_W-1:CHAN_W];
    q_times = ((2*CHAN_W+1)'(q_est) << CHAN_W) - (2*CHAN_W+1)'(q_est);
    rem     = {1'b0, prod_r} - q_times;
    scaled  = (rem >= FULL) ? q_est + CHAN_W'(1) : q_est;
  end

endmodule

`default_nettype wire

>>> hdl/alfd_pixmem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alfd_pixmem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alfd_pixmem #(
  parameter int DEPTH = alfd_pkg::LED_COUNT_DEF,
  parameter int AW    = 3
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [alfd_pkg::PIXEL_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [alfd_pkg::PIXEL_W-1:0] rd_data
);
  import alfd_pkg::*;

  logic [PIXEL_W-1:0] mem_r [DEPTH];
  logic [PIXEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> tb/tb_addressable_led_frame_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_driver_core
// Self-checking bench for the LED frame driver: directed commands, then
// random frames with random pixel content, phase lengths and brightness.
// Every result word is compared against an in-bench model of the frame
// store and the bit serialiser, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_driver_core;
  import alfd_pkg::*;

  localparam int LEDS = LED_COUNT_DEF;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } led_cmd_t;

  typedef struct packed {
    logic data_line;
    logic busy;
    logic rejected;
  } line_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op = OP_TICK;
  logic [INDEX_W-1:0]    in_index = '0;
  logic [CHAN_W-1:0]     in_red = '0;
  logic [CHAN_W-1:0]     in_green = '0;
  logic [CHAN_W-1:0]     in_blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_data_line;
  logic                  out_busy_res;
  logic                  out_rejected;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_BRIGHT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model state: frame store, serialiser position and register copies
  logic [PIXEL_W-1:0] led_frame [LEDS];
  int                 led_ptr;
  int                 bit_ptr;
  logic [PHASE_W-1:0] phase_cnt;
  logic               high_phase;
  logic               frame_on;
  logic               line_level;
  logic [CHAN_W-1:0]  bright_max;
  logic [PHASE_W-1:0] short_len;
  logic [PHASE_W-1:0] long_len;

  led_cmd_t     pending_cmds [$];
  line_status_t line_expect [$];
  int           taken_seen = 0;
  logic         idle_on = 1'b1;
  int           accepted_cnt = 0;
  int           stall_left = 0;
  logic         stall_done = 1'b0;
  int           errors = 0;

  addressable_led_frame_driver_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_index      (in_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_line (out_data_line),
    .out_busy_res  (out_busy_res),
    .out_rejected  (out_rejected),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] ch);
    return CHAN_W'((int'(ch) * int'(bright_max)) / CHAN_FULL);
  endfunction

  // Advance the model by one word and return the status it leaves behind
  function automatic line_status_t predict_line(led_cmd_t c);
    logic [PIXEL_W-1:0] grb;
    logic               one;
    logic [PHASE_W-1:0] dur;
    line_status_t       r;
    grb = {scale_chan(c.green), scale_chan(c.red), scale_chan(c.blue)};
    r.rejected = 1'b0;
    if (c.op == OP_TICK) begin
      if (frame_on) begin
        one = led_frame[led_ptr][BITS_PER_LED - 1 - bit_ptr];
        if (high_phase) dur = one ? long_len : short_len;
        else            dur = one ? short_len : long_len;
        line_level = high_phase;
        phase_cnt = phase_cnt + 1'b1;
        // a zero length acts as one slot
        if (phase_cnt >= dur || phase_cnt == '0) begin
          phase_cnt = '0;
          if (high_phase) begin
            high_phase = 1'b0;
          end else begin
            bit_ptr++;
            if (bit_ptr >= BITS_PER_LED) begin
              bit_ptr = 0;
              led_ptr++;
            end
            if (led_ptr >= LEDS) begin
              led_ptr = 0;
              frame_on = 1'b0;
              high_phase = 1'b0;
            end else begin
              high_phase = 1'b1;
            end
          end
        end
      end else begin
        line_level = 1'b0;
      end
    end else if (frame_on) begin
      r.rejected = 1'b1;
    end else if (c.op == OP_SET) begin
      if (c.index >= LEDS) r.rejected = 1'b1;
      else led_frame[c.index] = grb;
    end else if (c.op == OP_FILL) begin
      for (int i = 0; i < LEDS; i++) led_frame[i] = grb;
    end else begin
      frame_on = 1'b1;
      led_ptr = 0;
      bit_ptr = 0;
      phase_cnt = '0;
      high_phase = 1'b1;
      line_level = 1'b0;
    end
    r.data_line = line_level;
    r.busy = frame_on;
    return r;
  endfunction

  // Sender: present the head of the pending queue, hold it until taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || accepted_cnt != taken_seen)) begin
      taken_seen = accepted_cnt;
      if (pending_cmds.size() != 0 && !(idle_on && $urandom_range(99) < 22)) begin
        {in_op, in_index, in_red, in_green, in_blue} = pending_cmds[0];
        in_valid = 1'b1;
      end else begin
        in_valid = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      line_expect.push_back(predict_line(pending_cmds.pop_front()));
      accepted_cnt++;
    end
  end

  // Receiver: random back-pressure plus one long hold-off to fill the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (!stall_done && accepted_cnt >= 300 && pending_cmds.size() >= 8) begin
      stall_done = 1'b1;
      stall_left = 150;
      out_ready = 1'b0;
    end else begin
      out_ready = !(idle_on && $urandom_range(99) < 22);
    end
  end

  task automatic check_bit(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    line_status_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (line_expect.size() == 0) begin
        $display("%0t: unexpected word, expected none, got line=%0b busy=%0b rej=%0b",
                 $time, out_data_line, out_busy_res, out_rejected);
        errors++;
      end else begin
        exp_w = line_expect.pop_front();
        check_bit("data_line", exp_w.data_line, out_data_line);
        check_bit("busy_res", exp_w.busy, out_busy_res);
        check_bit("rejected", exp_w.rejected, out_rejected);
      end
    end
  end

  task automatic push_cmd(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                          logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                          logic [CHAN_W-1:0] b);
    led_cmd_t c;
    c.op = op;
    c.index = idx;
    c.red = r;
    c.green = g;
    c.blue = b;
    pending_cmds.push_back(c);
  endtask

  // Hold until every word has come back, then let a trailing fill finish
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || line_expect.size() != 0) @(posedge clk);
    repeat (LEDS + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      CFG_MAX_BRIGHT: bright_max = data;
      CFG_SHORT:      short_len = data[PHASE_W-1:0];
      CFG_LONG:       long_len = data[PHASE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] phase_word(int len);
    // upper bits carry junk; only the low nibble counts
    return {4'($urandom), 4'(len)};
  endfunction

  initial begin
    int rand_items;
    int chunk_no;
    int n;
    for (int i = 0; i < LEDS; i++) led_frame[i] = '0;
    led_ptr = 0;
    bit_ptr = 0;
    phase_cnt = '0;
    high_phase = 1'b0;
    frame_on = 1'b0;
    line_level = 1'b0;
    bright_max = MAX_BRIGHT_RST;
    short_len = SHORT_RST;
    long_len = LONG_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle tick, edge indexes, rejects, fill, show, commands while busy
    push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_TICK, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(OP_SET, 8'd0, 8'hff, 8'hff, 8'hff);
    push_cmd(OP_SET, 8'(LEDS - 1), 8'h00, 8'h00, 8'h00);
    push_cmd(OP_SET, 8'(LEDS), 8'h12, 8'h34, 8'h56);
    push_cmd(OP_SET, 8'hff, 8'hff, 8'hff, 8'hff);
    push_cmd(OP_FILL, 8'h00, 8'hff, 8'h00, 8'h80);
    push_cmd(OP_SET, 8'd3, 8'h01, 8'hfe, 8'hff);
    push_cmd(OP_SET, 8'd0, 8'hff, 8'hff, 8'hff);
    push_cmd(OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_SET, 8'd1, 8'hff, 8'hff, 8'hff);
    push_cmd(OP_FILL, 8'h00, 8'h55, 8'haa, 8'h55);
    push_cmd(OP_SHOW, 8'hff, 8'hff, 8'hff, 8'hff);
    repeat (12) push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    // Random frames; a frame left running carries on in the next round of ticks
    rand_items = 0;
    chunk_no = 0;
    while (rand_items < 1850 || frame_on) begin
      idle_on = !(rand_items >= 600 && rand_items < 1000);
      if (!frame_on) begin
        case ($urandom_range(3))
          0:       write_reg(CFG_MAX_BRIGHT, 8'd0);
          1:       write_reg(CFG_MAX_BRIGHT, 8'd255);
          default: write_reg(CFG_MAX_BRIGHT, 8'($urandom));
        endcase
        write_reg(CFG_SHORT, phase_word($urandom_range(0, 3)));
        write_reg(CFG_LONG, phase_word($urandom_range(0, 3)));
        n = $urandom_range(1, 12);
        repeat (n) begin
          case ($urandom_range(7))
            0: push_cmd(OP_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            1: push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            2: push_cmd(OP_SET, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            default: push_cmd(OP_SET, 8'($urandom_range(LEDS - 1)), 8'($urandom),
                              8'($urandom), 8'($urandom));
          endcase
        end
        push_cmd(OP_SHOW, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        rand_items += n + 1;
      end
      // Ticks with the odd stray command mixed in
      repeat (48) begin
        if ($urandom_range(9) == 0)
          push_cmd(OP_W'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
        else
          push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        rand_items++;
      end
      wait_drained();
      chunk_no++;
      if (frame_on) begin
        // Change phase lengths mid-frame; drop long settings again soon after
        if (rand_items >= 1850) begin
          // finish the last frame with the shortest bits
          write_reg(CFG_SHORT, phase_word(1));
          write_reg(CFG_LONG, phase_word(1));
        end else if (short_len > 3 || long_len > 3) begin
          write_reg(CFG_SHORT, phase_word($urandom_range(0, 3)));
          write_reg(CFG_LONG, phase_word($urandom_range(1, 3)));
        end else if (chunk_no % 5 == 4) begin
          write_reg(CFG_SHORT, phase_word(15));
          write_reg(CFG_LONG, phase_word($urandom_range(0, 15)));
        end else if ($urandom_range(5) == 0) begin
          write_reg(CFG_SHORT, phase_word($urandom_range(1, 3)));
          write_reg(CFG_LONG, phase_word($urandom_range(0, 3)));
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS addressable_led_frame_driver_core");
    end else begin
      $display("FAIL addressable_led_frame_driver_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL addressable_led_frame_driver_core");
    $finish;
  end

endmodule

>>> files.f
hdl/alfd_pkg.sv
hdl/alfd_scale.sv
hdl/alfd_pixmem.sv
hdl/addressable_led_frame_driver_core.sv
tb/tb_addressable_led_frame_driver_core.sv
